### rtl/cskc_pkg.sv
// ----------------------------------------------------------------------------
// cskc_pkg
// shared sizes, types and result codes of the clock sweep key cache
// ----------------------------------------------------------------------------
package cskc_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 32;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int CAP_W   = 5;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int KIN_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [STAT_W-1:0] ST_GET_HIT     = 3'd0;
  localparam logic [STAT_W-1:0] ST_GET_MISS    = 3'd1;
  localparam logic [STAT_W-1:0] ST_PUT_PRESENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_PUT_FREE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_PUT_REPLACE = 3'd4;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    key_t wr_data;
  } store_req_t;

  typedef struct packed {
    key_t rd_data;
    logic match;
  } store_rsp_t;

endpackage

### rtl/cskc_store.sv
// ----------------------------------------------------------------------------
// cskc_store
// key memory with registered read and the shared key comparator
// ----------------------------------------------------------------------------
module cskc_store (
  input  logic                clk_i,
  input  cskc_pkg::store_req_t req_i,
  input  cskc_pkg::key_t      key_i,
  output cskc_pkg::store_rsp_t rsp_o
);
  import cskc_pkg::*;

  key_t mem [ENTRIES];
  key_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // shared compare unit
  assign rsp_o.rd_data = rd_data_q;
  assign rsp_o.match   = (rd_data_q == key_i);

endmodule

### rtl/clock_sweep_key_cache_core.sv
// ----------------------------------------------------------------------------
// clock_sweep_key_cache_core
// key cache with clock (second-chance) replacement, scanned one slot at a time
//
//   channel | direction | signals
//   in      | input     | in_valid_i, in_ready_o, command_i, key_in_i
//   out     | output    | out_valid_o, out_ready_i, status_o, slot_o, key_out_o
//   cfg     | input     | cfg_valid_i, cfg_ready_o, cfg_capacity_i
//
// one transaction at a time; the single key comparator and memory read port
// set the pace: each filled slot scanned is read, then compared; a hit, a
// miss or a put into a free slot then finishes through the done step.
// a replacement clears set reference bits (up to capacity), then replaces one.
// reset clears reference bits, hand and fill count; key memory needs no clear.
// a waiting result stalls the next transaction at its last step, so input
// ready stays low until the output register frees up.
// ----------------------------------------------------------------------------
module clock_sweep_key_cache_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic signed [cskc_pkg::KIN_W-1:0] key_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cskc_pkg::STAT_W-1:0]    status_o,
  output logic [cskc_pkg::SLOT_W-1:0]    slot_o,
  output logic signed [cskc_pkg::KIN_W-1:0] key_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cskc_pkg::CAP_W-1:0]     cfg_capacity_i
);
  import cskc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;
  localparam logic [2:0] S_SCAN_CM = 3'd2;
  localparam logic [2:0] S_MISS    = 3'd3;
  localparam logic [2:0] S_SWEEP   = 3'd4;
  localparam logic [2:0] S_REPL    = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [ENTRIES-1:0] ref_q, ref_d;
  idx_t               hand_q, hand_d;
  cnt_t               fill_q, fill_d;
  idx_t               idx_q, idx_d;
  logic               cmd_q, cmd_d;
  key_t               key_q, key_d;
  logic [STAT_W-1:0]  res_stat_q, res_stat_d;
  idx_t               res_slot_q, res_slot_d;
  key_t               res_key_q, res_key_d;
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [KIN_W-1:0]   out_key_q, out_key_d;

  cnt_t        cap_eff;
  logic [63:0] key_wide;
  logic [63:0] res_key_wide;
  idx_t        idx_next;
  store_req_t  req;
  store_rsp_t  rsp;

  cskc_store u_store (
    .clk_i (clk_i),
    .req_i (req),
    .key_i (key_q),
    .rsp_o (rsp)
  );

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = cnt_t'(1);
    end else if (32'(cap_q) > 32'(ENTRIES)) begin
      cap_eff = cnt_t'(ENTRIES);
    end else begin
      cap_eff = cnt_t'(cap_q);
    end
  end

  assign key_wide     = {{32{key_in_i[KIN_W-1]}}, key_in_i};
  assign res_key_wide = 64'(res_key_q);
  assign idx_next     = ((cnt_t'(idx_q) + cnt_t'(1)) == cap_eff) ? '0 : idx_t'(idx_q + idx_t'(1));

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign slot_o      = out_slot_q;
  assign key_out_o   = out_key_q;

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    ref_d       = ref_q;
    hand_d      = hand_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    res_stat_d  = res_stat_q;
    res_slot_d  = res_slot_q;
    res_key_d   = res_key_q;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_slot_d  = out_slot_q;
    out_key_d   = out_key_q;
    req         = '0;

    if (cfg_valid_i) begin
      cap_d = cfg_capacity_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          key_d   = key_wide[KEY_BITS-1:0];
          idx_d   = '0;
          state_d = (fill_q == '0) ? S_MISS : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx_q;
        state_d     = S_SCAN_CM;
      end
      S_SCAN_CM: begin
        if (rsp.match) begin
          ref_d[idx_q] = 1'b1;
          res_slot_d   = idx_q;
          if (cmd_q == CMD_GET) begin
            res_stat_d = ST_GET_HIT;
            res_key_d  = rsp.rd_data;
          end else begin
            res_stat_d = ST_PUT_PRESENT;
            res_key_d  = '0;
          end
          state_d = S_DONE;
        end else if ((cnt_t'(idx_q) + cnt_t'(1)) == fill_q) begin
          state_d = S_MISS;
        end else begin
          idx_d   = idx_t'(idx_q + idx_t'(1));
          state_d = S_SCAN_RD;
        end
      end
      S_MISS: begin
        if (cmd_q == CMD_GET) begin
          res_stat_d = ST_GET_MISS;
          res_slot_d = '0;
          res_key_d  = '0;
          state_d    = S_DONE;
        end else if (fill_q < cap_eff) begin
          req.wr_en          = 1'b1;
          req.wr_addr        = idx_t'(fill_q);
          req.wr_data        = key_q;
          ref_d[idx_t'(fill_q)] = 1'b1;
          fill_d             = cnt_t'(fill_q + cnt_t'(1));
          res_stat_d         = ST_PUT_FREE;
          res_slot_d         = idx_t'(fill_q);
          res_key_d          = '0;
          state_d            = S_DONE;
        end else begin
          idx_d   = (cnt_t'(hand_q) < cap_eff) ? hand_q : '0;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (ref_q[idx_q]) begin
          ref_d[idx_q] = 1'b0;
          idx_d        = idx_next;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = idx_q;
          state_d     = S_REPL;
        end
      end
      S_REPL: begin
        req.wr_en    = 1'b1;
        req.wr_addr  = idx_q;
        req.wr_data  = key_q;
        ref_d[idx_q] = 1'b1;
        hand_d       = idx_next;
        res_stat_d   = ST_PUT_REPLACE;
        res_slot_d   = idx_q;
        res_key_d    = rsp.rd_data;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_slot_d  = SLOT_W'(res_slot_q);
          out_key_d   = res_key_wide[KIN_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      ref_q       <= '0;
      hand_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      ref_q       <= ref_d;
      hand_q      <= hand_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    res_stat_q <= res_stat_d;
    res_slot_q <= res_slot_d;
    res_key_q  <= res_key_d;
    out_stat_q <= out_stat_d;
    out_slot_q <= out_slot_d;
    out_key_q  <= out_key_d;
  end

endmodule
